### src/assert_macros.svh
// Assertion macros used by the property checker (rdas_props)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define AST_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/rdas_pkg.sv
`default_nettype none
package rdas_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int OCC_W    = 7;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 80;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [31:0] area;
        logic [15:0] rect_length;
        logic [15:0] rect_width;
    } t_rec;

    typedef struct packed {
        logic shift_back;
        logic shift_front;
        logic load;
    } t_cell_ctl;

endpackage
`default_nettype wire

### src/rdas_cell.sv
`default_nettype none
module rdas_cell
    import rdas_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_rec      i_prev,
    input  wire t_rec      i_next,
    input  wire t_rec      i_ins,
    output t_rec           o_rec
);

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_back) begin
            r_rec <= i_prev;
        end else if (i_ctl.shift_front) begin
            r_rec <= i_next;
        end else if (i_ctl.load) begin
            r_rec <= i_ins;
        end
    end

    assign o_rec = r_rec;

endmodule
`default_nettype wire

### src/rect_deque_area_search_top.sv
// Double-ended queue of rectangle records with search by area.
// Input stream: one word per operation on s_axis (op, width, length, key).
// Output stream: exactly one result word per operation on m_axis (status,
// matched width, length, area, position from the front, occupancy).
// Records sit in a row of cells; cell 0 always holds the front record.
// Push front, pop front, push back, pop back and unused ops are answered
// directly: the result word is valid in the cycle after the input word is taken.
// A search rotates the whole row past cell 0, one record per cycle, whatever
// the occupancy, then writes the result once the output side is free; the
// row is back in place when the result appears.
// One operation is in flight at a time; the next input word is taken once
// the previous result word has been written, at the earliest in the cycle
// that result is drained, so non-search ops can follow back to back.
// A stalled receiver holds the result word; tready on the input side stays
// low until there is room for the next result.
// Synchronous active-low reset empties the queue and drops any pending
// result; the record contents are not cleared.
`default_nettype none
module rect_deque_area_search_top
    import rdas_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // op[2:0], rect_width[18:3], rect_length[34:19], search_area[66:35]
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // status[1:0], found_width[17:2], found_length[33:18], found_area[65:34],
    // found_position[71:66], occupancy[78:72]
    output logic [OUT_W-1:0]      o_m_axis_tdata
);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_DONE} t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_step;
    logic [31:0]        r_key;
    logic               r_found;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [15:0]        r_fw;
    logic [15:0]        r_fl;
    logic [31:0]        r_fa;
    logic [POS_W-1:0]   r_fp;

    logic [2:0]         w_op;
    logic [15:0]        w_width;
    logic [15:0]        w_length;
    logic [31:0]        w_key;
    logic               w_accept;
    logic               w_out_free;
    logic               w_result_set;
    logic               w_full;
    logic               w_empty;
    logic               w_hit;
    t_rec               w_ins;
    t_rec               w_rec  [CAPACITY];
    t_rec               w_prev [CAPACITY];
    t_rec               w_next [CAPACITY];
    t_cell_ctl          w_ctl  [CAPACITY];

    assign w_op     = i_s_axis_tdata[2:0];
    assign w_width  = i_s_axis_tdata[18:3];
    assign w_length = i_s_axis_tdata[34:19];
    assign w_key    = i_s_axis_tdata[66:35];

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CNT_W'(CAPACITY));
    assign w_empty         = (r_count == '0);
    assign w_result_set    = (w_accept && (w_op != OP_SEARCH))
                             || ((r_state == S_DONE) && w_out_free);

    assign w_ins = '{area:        {16'd0, w_width} * {16'd0, w_length},
                     rect_length: w_length,
                     rect_width:  w_width};

    assign w_hit = !r_found && (CNT_W'(r_step) < r_count) && (w_rec[0].area == r_key);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_prev[gi] = w_ins;
            end else begin : g_body
                assign w_prev[gi] = w_rec[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign w_next[gi] = w_rec[0];
            end else begin : g_inner
                assign w_next[gi] = w_rec[gi+1];
            end

            assign w_ctl[gi] = '{
                shift_back:  w_accept && (w_op == OP_PUSH_FRONT) && !w_full,
                shift_front: (w_accept && (w_op == OP_POP_FRONT) && !w_empty)
                             || (r_state == S_SEARCH),
                load:        w_accept && (w_op == OP_PUSH_BACK) && !w_full
                             && (r_count == CNT_W'(gi))
            };

            rdas_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl[gi]),
                .i_prev (w_prev[gi]),
                .i_next (w_next[gi]),
                .i_ins  (w_ins),
                .o_rec  (w_rec[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_result_set) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_fw     <= '0;
                        r_fl     <= '0;
                        r_fa     <= '0;
                        r_fp     <= '0;
                        case (w_op)
                            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_count  <= r_count + CNT_W'(1);
                                end
                            end
                            OP_POP_FRONT, OP_POP_BACK: begin
                                if (w_empty) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_status <= ST_OK;
                                    r_count  <= r_count - CNT_W'(1);
                                end
                            end
                            OP_SEARCH: begin
                                r_key   <= w_key;
                                r_step  <= '0;
                                r_found <= 1'b0;
                                r_state <= S_SEARCH;
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_fw    <= w_rec[0].rect_width;
                        r_fl    <= w_rec[0].rect_length;
                        r_fa    <= w_rec[0].area;
                        r_fp    <= POS_W'(r_step);
                    end
                    r_step <= r_step + IDX_W'(1);
                    if (r_step == IDX_W'(CAPACITY - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_status    <= r_found ? ST_OK : ST_MISS;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, OCC_W'(r_count), r_fp, r_fa, r_fl, r_fw, r_status};

endmodule
`default_nettype wire

### src/rdas_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rdas_props
    import rdas_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_axis_tvalid,
    input wire logic             i_s_axis_tready,
    input wire logic [IN_W-1:0]  i_s_axis_tdata,
    input wire logic             i_m_axis_tvalid,
    input wire logic             i_m_axis_tready,
    input wire logic [OUT_W-1:0] i_m_axis_tdata
);

    logic [1:0]       w_status;
    logic [63:0]      w_found;
    logic [OCC_W-1:0] w_occ;
    logic             w_in_acc;
    logic             w_res_empty;
    logic             w_res_full;
    logic             w_res_miss;

    assign w_status    = i_m_axis_tdata[1:0];
    assign w_found     = i_m_axis_tdata[65:2];
    assign w_occ       = i_m_axis_tdata[78:72];
    assign w_in_acc    = i_s_axis_tvalid && i_s_axis_tready
                         && (i_s_axis_tdata[2:0] != OP_SEARCH);
    assign w_res_empty = i_m_axis_tvalid && (w_status == ST_EMPTY);
    assign w_res_full  = i_m_axis_tvalid && (w_status == ST_FULL);
    assign w_res_miss  = i_m_axis_tvalid && (w_status != ST_OK);

    `AST_NOW(a_occ_bound, i_clk, i_rst_n, i_m_axis_tvalid, w_occ <= OCC_W'(CAPACITY))
    `AST_NOW(a_empty_occ, i_clk, i_rst_n, w_res_empty, w_occ == '0)
    `AST_NOW(a_full_occ, i_clk, i_rst_n, w_res_full, w_occ == OCC_W'(CAPACITY))
    `AST_NOW(a_miss_zero, i_clk, i_rst_n, w_res_miss, w_found == '0)
    `AST_NEXT(a_quick_result, i_clk, i_rst_n, w_in_acc, i_m_axis_tvalid)

endmodule

bind rect_deque_area_search_top rdas_props u_rdas_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

### tb/rdas_checker.sv
`default_nettype none
module rdas_checker
    import rdas_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_s_tready,
    // op[2:0], rect_width[18:3], rect_length[34:19], search_area[66:35]
    input  wire logic [IN_W-1:0]  i_s_tdata,
    input  wire logic             i_m_tvalid,
    input  wire logic             i_m_tready,
    // status[1:0], found_width[17:2], found_length[33:18], found_area[65:34],
    // found_position[71:66], occupancy[78:72]
    input  wire logic [OUT_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        logic [POS_W-1:0] position;
        logic [31:0]      area;
        logic [15:0]      rect_length;
        logic [15:0]      rect_width;
        logic [1:0]       status;
    } t_outcome;

    t_rec             shelf [CAPACITY];
    logic [IDX_W-1:0] front_slot = '0;
    logic [CNT_W-1:0] held = '0;
    t_outcome         due_outcomes [$];
    int               fails = 0;

    function automatic t_outcome apply_deque_op(input logic [IN_W-1:0] word);
        logic [2:0]       op;
        logic [15:0]      w;
        logic [15:0]      l;
        logic [31:0]      key;
        logic [IDX_W-1:0] slot;
        t_outcome         r;
        op  = word[2:0];
        w   = word[18:3];
        l   = word[34:19];
        key = word[66:35];
        r   = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        front_slot = front_slot - 1'b1;
                        slot = front_slot;
                    end else begin
                        slot = front_slot + IDX_W'(held);
                    end
                    shelf[slot] = '{area: 32'(w) * 32'(l), rect_length: l, rect_width: w};
                    held = held + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (op == OP_POP_FRONT) begin
                        front_slot = front_slot + 1'b1;
                    end
                    held = held - 1'b1;
                end
            end
            OP_SEARCH: begin
                r.status = ST_MISS;
                for (int i = 0; i < int'(held); i++) begin
                    slot = front_slot + IDX_W'(i);
                    if (r.status == ST_MISS && shelf[slot].area == key) begin
                        r.status      = ST_OK;
                        r.rect_width  = shelf[slot].rect_width;
                        r.rect_length = shelf[slot].rect_length;
                        r.area        = shelf[slot].area;
                        r.position    = POS_W'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            front_slot = '0;
            held       = '0;
            due_outcomes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_outcome'(i_m_tdata[78:0]);
                if (due_outcomes.size() == 0) begin
                    $error("result word with no operation outstanding");
                    fails++;
                end else begin
                    want = due_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("found_width", 32'(want.rect_width), 32'(got.rect_width));
                    check_field("found_length", 32'(want.rect_length),
                                32'(got.rect_length));
                    check_field("found_area", want.area, got.area);
                    check_field("found_position", 32'(want.position), 32'(got.position));
                    check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due_outcomes.push_back(apply_deque_op(i_s_tdata));
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_outcomes.size();
    end

endmodule
`default_nettype wire

### tb/tb_rect_deque_area_search_top.sv
`default_nettype none
module tb_rect_deque_area_search_top
    import rdas_pkg::*;
();

    localparam int         LIMIT      = 600000;
    localparam int         N_RANDOM   = 1150;
    localparam int         HOLD_LEN   = 400;
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    int               cycles = 0;
    bit               no_idle = 1'b0;
    bit               hold_off_req = 1'b0;
    logic [31:0]      recent_area [8];
    int               recent_ptr = 0;

    always #10 clk = ~clk;

    rect_deque_area_search_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    rdas_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_dim();
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'd3;
            4: return 16'd12;
            5: return 16'd255;
            6: return 16'd4096;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return 32'(pick_dim()) * 32'(pick_dim());
        end else if (r < 8) begin
            return recent_area[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_op(input int push_share);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            case ($urandom_range(0, 2))
                0: return OP_SPARE_5;
                1: return OP_SPARE_6;
                default: return OP_SPARE_7;
            endcase
        end else if (r < 28) begin
            return OP_SEARCH;
        end else if (r < 28 + push_share) begin
            return ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        return ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    task automatic offer(input logic [2:0] op, input logic [15:0] w,
                         input logic [15:0] l, input logic [31:0] key);
        s_tdata  <= {5'b0, key, l, w, op};
        s_tvalid <= 1'b1;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            recent_area[recent_ptr] = 32'(w) * 32'(l);
            recent_ptr = (recent_ptr + 1) % 8;
        end
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic offer_random(input int push_share);
        logic [2:0] op;
        op = pick_op(push_share);
        offer(op, pick_dim(), pick_dim(), pick_key());
    endtask

    initial begin
        int n;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                n = 0;
                while (n < HOLD_LEN) begin
                    @(posedge clk);
                    n++;
                end
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat (no_idle ? 1 : $urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    initial begin
        int push_share;
        foreach (recent_area[k]) recent_area[k] = '0;
        push_share = 36;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        offer(OP_POP_FRONT, 16'd0, 16'd0, 32'd0);
        offer(OP_POP_BACK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        offer(OP_SEARCH, 16'd0, 16'd0, 32'd0);
        offer(OP_PUSH_FRONT, 16'd0, 16'd0, 32'd0);
        offer(OP_PUSH_BACK, 16'hFFFF, 16'hFFFF, 32'd0);
        offer(OP_PUSH_FRONT, 16'd1, 16'hFFFF, 32'd0);
        offer(OP_PUSH_BACK, 16'hFFFF, 16'd1, 32'hFFFF_FFFF);
        offer(OP_SEARCH, 16'd0, 16'd0, 32'd65535);
        offer(OP_SEARCH, 16'd0, 16'd0, 32'hFFFE_0001);
        offer(OP_SEARCH, 16'hFFFF, 16'hFFFF, 32'd0);
        offer(OP_SEARCH, 16'd0, 16'd0, 32'd12345);
        offer(OP_SEARCH, 16'd0, 16'd0, 32'hFFFF_FFFF);
        offer(OP_SPARE_5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        offer(OP_SPARE_6, 16'hAAAA, 16'h5555, 32'hFFFE_0001);
        offer(OP_SPARE_7, 16'h5555, 16'hAAAA, 32'h0000_0000);
        offer(OP_POP_FRONT, 16'd0, 16'd0, 32'd0);
        offer(OP_POP_BACK, 16'd0, 16'd0, 32'd0);
        offer(OP_SEARCH, 16'd0, 16'd0, 32'd65535);
        offer(OP_PUSH_FRONT, 16'hAAAA, 16'h5555, 32'd0);
        offer(OP_PUSH_BACK, 16'h5555, 16'hAAAA, 32'd0);
        offer(OP_SEARCH, 16'd0, 16'd0, 32'(16'hAAAA) * 32'(16'h5555));

        repeat (64) begin
            offer($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                  pick_dim(), pick_dim(), 32'd0);
        end
        offer(OP_SEARCH, 16'd0, 16'd0, recent_area[$urandom_range(0, 7)]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 80 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_share = 55;
                    1: push_share = 15;
                    default: push_share = 36;
                endcase
            end
            if (i == 300) begin
                hold_off_req = 1'b1;
            end
            if (i >= N_RANDOM - 100) begin
                no_idle = 1'b1;
            end
            offer_random(push_share);
            if (i == 600 || i == 900) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
